[rtl/core/ascl_pkg.sv]
`timescale 1ns / 1ps

package ascl_pkg;

   // field widths
   localparam int SAMPLE_W   = 12;
   localparam int MEAN_W     = 12;
   localparam int DIST_W     = 18;
   localparam int COEF_W     = 56;
   localparam int ACC_W      = 64;
   localparam int FRAC_SHIFT = 32;
   localparam int CSR_IDX_W  = 3;

   // group size default
   localparam int SAMPLES_DEF = 16;

   // queue between front and back, power of two
   localparam int FIFO_DEPTH = 2;

   // coefficient reset values, signed Q.40
   localparam logic signed [COEF_W-1:0] COEF_CONST_RST  = 56'sd199011604627456;
   localparam logic signed [COEF_W-1:0] COEF_LINEAR_RST = -56'sd217703302300;
   localparam logic signed [COEF_W-1:0] COEF_SQUARE_RST = 56'sd87740928;
   localparam logic signed [COEF_W-1:0] COEF_CUBE_RST   = -56'sd11985;

   // register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_COEF_CONST  = 3'd0,
      CSR_COEF_LINEAR = 3'd1,
      CSR_COEF_SQUARE = 3'd2,
      CSR_COEF_CUBE   = 3'd3
   } csr_index_type;

   // queue status toward front and back
   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

   // back end sequencer
   typedef enum logic [2:0] {
      BK_IDLE,
      BK_DIV,
      BK_MUL,
      BK_ADD,
      BK_ROUND
   } back_state_type;

endpackage

[rtl/core/ascl_front.sv]
`timescale 1ns / 1ps

module ascl_front import ascl_pkg::*; #(
   parameter int SAMPLES = SAMPLES_DEF,
   parameter int SUM_W   = SAMPLE_W + $clog2(SAMPLES_DEF)
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [SAMPLE_W-1:0] req_sample,
   input  q_status_type        q_stat,
   output logic                push,
   output logic [SUM_W-1:0]    push_sum
);

   localparam int CNT_W = $clog2(SAMPLES);
   localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(SAMPLES - 1);

   logic [CNT_W-1:0] count_ff, count_in;
   logic [SUM_W-1:0] sum_ff, sum_in;
   logic             accept;
   logic [SUM_W-1:0] sum_next;

   // take samples while the queue has room
   assign req_ready = !q_stat.full;
   assign accept    = req_valid && req_ready;
   assign sum_next  = sum_ff + SUM_W'(req_sample);

   // last sample of a group hands the sum to the back end
   assign push     = accept && (count_ff == LAST_CNT);
   assign push_sum = sum_next;

   // group accumulation
   always_comb begin
      count_in = count_ff;
      sum_in   = sum_ff;
      if (accept) begin
         if (count_ff == LAST_CNT) begin
            count_in = '0;
            sum_in   = '0;
         end else begin
            count_in = count_ff + 1'b1;
            sum_in   = sum_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         sum_ff   <= '0;
      end else begin
         count_ff <= count_in;
         sum_ff   <= sum_in;
      end
   end

endmodule

[rtl/core/ascl_fifo.sv]
`timescale 1ns / 1ps

module ascl_fifo import ascl_pkg::*; #(
   parameter int DATA_W = SAMPLE_W + $clog2(SAMPLES_DEF)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  logic [DATA_W-1:0] push_data,
   input  logic              pop,
   output logic [DATA_W-1:0] pop_data,
   output q_status_type      q_stat
);

   localparam int PTR_W = $clog2(FIFO_DEPTH);
   localparam logic [PTR_W:0] FULL_CNT = (PTR_W+1)'(FIFO_DEPTH);

   logic [DATA_W-1:0] mem_ff [FIFO_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [PTR_W:0]    count_ff, count_in;

   assign q_stat.full  = (count_ff == FULL_CNT);
   assign q_stat.empty = (count_ff == '0);
   assign pop_data     = mem_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = push ? PTR_W'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = pop  ? PTR_W'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

`ifndef NO_ASSERTIONS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !q_stat.full || pop)
      else $error("queue written while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !q_stat.empty)
      else $error("queue read while empty");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_CNT)
      else $error("queue fill count out of range");
`endif

endmodule

[rtl/core/ascl_back.sv]
`timescale 1ns / 1ps

module ascl_back import ascl_pkg::*; #(
   parameter int SAMPLES = SAMPLES_DEF,
   parameter int SUM_W   = SAMPLE_W + $clog2(SAMPLES_DEF)
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [CSR_IDX_W-1:0]     csr_index,
   input  logic signed [COEF_W-1:0] csr_wdata,
   input  q_status_type             q_stat,
   input  logic [SUM_W-1:0]         pop_sum,
   output logic                     pop,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [MEAN_W-1:0]        rsp_mean_value,
   output logic signed [DIST_W-1:0] rsp_distance,
   output logic                     rsp_saturated
);

   localparam int PROD_W    = ACC_W + MEAN_W + 1;
   localparam int Q_W       = ACC_W - FRAC_SHIFT + 1;
   localparam int DIV_SHIFT = SUM_W + $clog2(SAMPLES);
   localparam int RECIP_W   = SUM_W + 1;
   localparam int MQ_W      = SUM_W + RECIP_W;
   localparam logic [RECIP_W-1:0] RECIP =
      RECIP_W'(((64'd1 << DIV_SHIFT) + 64'(SAMPLES) - 64'd1) / 64'(SAMPLES));
   localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
   localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
   localparam logic signed [Q_W-1:0] Q_MAX = Q_W'((2 ** (DIST_W - 1)) - 1);
   localparam logic signed [Q_W-1:0] Q_MIN = -Q_W'(2 ** (DIST_W - 1));
   localparam logic signed [DIST_W-1:0] DIST_MAX = DIST_W'((2 ** (DIST_W - 1)) - 1);
   localparam logic signed [DIST_W-1:0] DIST_MIN = DIST_W'(-(2 ** (DIST_W - 1)));

   // coefficients
   logic signed [COEF_W-1:0] coef_const_ff, coef_linear_ff, coef_square_ff, coef_cube_ff;

   // sequencer and datapath
   back_state_type           state_ff, state_in;
   logic [SUM_W-1:0]         sum_ff, sum_in;
   logic [MEAN_W-1:0]        quot_ff, quot_in;
   csr_index_type            term_ff, term_in;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;

   // output register
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [MEAN_W-1:0]        mean_ff;
   logic signed [DIST_W-1:0] dist_ff;
   logic                     sat_ff;

   logic                     out_load;
   logic [MQ_W-1:0]          mq;
   logic signed [ACC_W-1:0]  prod_sat;
   logic signed [ACC_W-1:0]  coef_sel;
   logic signed [ACC_W:0]    add_wide;
   logic signed [ACC_W-1:0]  add_sat;
   logic signed [Q_W-1:0]    q_wide;
   logic signed [DIST_W-1:0] dist_clip;
   logic                     sat_clip;

   assign csr_ready      = 1'b1;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_mean_value = mean_ff;
   assign rsp_distance   = dist_ff;
   assign rsp_saturated  = sat_ff;

   // divide by the group size through a reciprocal multiply
   assign mq = MQ_W'(sum_ff) * MQ_W'(RECIP);

   // coefficient writes
   always_ff @(posedge clock) begin
      if (reset) begin
         coef_const_ff  <= COEF_CONST_RST;
         coef_linear_ff <= COEF_LINEAR_RST;
         coef_square_ff <= COEF_SQUARE_RST;
         coef_cube_ff   <= COEF_CUBE_RST;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_COEF_CONST:  coef_const_ff  <= csr_wdata;
            CSR_COEF_LINEAR: coef_linear_ff <= csr_wdata;
            CSR_COEF_SQUARE: coef_square_ff <= csr_wdata;
            CSR_COEF_CUBE:   coef_cube_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   // clamp the registered product to the accumulator range
   always_comb begin
      if ((&prod_ff[PROD_W-1:ACC_W-1]) || !(|prod_ff[PROD_W-1:ACC_W-1])) begin
         prod_sat = prod_ff[ACC_W-1:0];
      end else begin
         prod_sat = prod_ff[PROD_W-1] ? ACC_MIN : ACC_MAX;
      end
   end

   // coefficient for the current horner term
   always_comb begin
      case (term_ff)
         CSR_COEF_SQUARE: coef_sel = ACC_W'(coef_square_ff);
         CSR_COEF_LINEAR: coef_sel = ACC_W'(coef_linear_ff);
         default:         coef_sel = ACC_W'(coef_const_ff);
      endcase
   end

   // saturating add
   always_comb begin
      add_wide = {prod_sat[ACC_W-1], prod_sat} + {coef_sel[ACC_W-1], coef_sel};
      if (add_wide[ACC_W] != add_wide[ACC_W-1]) begin
         add_sat = add_wide[ACC_W] ? ACC_MIN : ACC_MAX;
      end else begin
         add_sat = add_wide[ACC_W-1:0];
      end
   end

   // round to nearest, ties up, then clip to the distance range
   always_comb begin
      q_wide = {acc_ff[ACC_W-1], acc_ff[ACC_W-1:FRAC_SHIFT]}
             + {{(Q_W-1){1'b0}}, acc_ff[FRAC_SHIFT-1]};
      if (q_wide > Q_MAX) begin
         dist_clip = DIST_MAX;
         sat_clip  = 1'b1;
      end else if (q_wide < Q_MIN) begin
         dist_clip = DIST_MIN;
         sat_clip  = 1'b1;
      end else begin
         dist_clip = q_wide[DIST_W-1:0];
         sat_clip  = 1'b0;
      end
   end

   // sequencer: divide, three multiply/add rounds, round
   always_comb begin
      state_in = state_ff;
      sum_in   = sum_ff;
      quot_in  = quot_ff;
      term_in  = term_ff;
      acc_in   = acc_ff;
      prod_in  = prod_ff;
      pop      = 1'b0;
      out_load = 1'b0;
      case (state_ff)
         BK_IDLE: begin
            if (!q_stat.empty) begin
               pop      = 1'b1;
               sum_in   = pop_sum;
               state_in = BK_DIV;
            end
         end
         BK_DIV: begin
            quot_in  = MEAN_W'(mq >> DIV_SHIFT);
            acc_in   = ACC_W'(coef_cube_ff);
            term_in  = CSR_COEF_SQUARE;
            state_in = BK_MUL;
         end
         BK_MUL: begin
            prod_in  = PROD_W'(acc_ff) * PROD_W'($signed({1'b0, quot_ff}));
            state_in = BK_ADD;
         end
         BK_ADD: begin
            acc_in = add_sat;
            if (term_ff == CSR_COEF_CONST) begin
               state_in = BK_ROUND;
            end else begin
               term_in  = csr_index_type'(term_ff - 1'b1);
               state_in = BK_MUL;
            end
         end
         BK_ROUND: begin
            if (!rsp_valid_ff || rsp_ready) begin
               out_load = 1'b1;
               state_in = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   // result valid flag
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      sum_ff  <= sum_in;
      quot_ff <= quot_in;
      term_ff <= term_in;
      acc_ff  <= acc_in;
      prod_ff <= prod_in;
      if (out_load) begin
         mean_ff <= quot_ff;
         dist_ff <= dist_clip;
         sat_ff  <= sat_clip;
      end
   end

`ifndef NO_ASSERTIONS
   a_sat_at_limit: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && sat_ff) |-> (dist_ff == DIST_MAX || dist_ff == DIST_MIN))
      else $error("saturated flag without a clipped distance");

   a_round_waits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BK_ROUND && rsp_valid_ff && !rsp_ready) |=> (state_ff == BK_ROUND))
      else $error("result left the sequencer while output stalled");

   a_term_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BK_MUL || state_ff == BK_ADD) |->
         (term_ff == CSR_COEF_SQUARE || term_ff == CSR_COEF_LINEAR ||
          term_ff == CSR_COEF_CONST))
      else $error("horner term out of range");
`endif

endmodule

[rtl/core/averaged_sample_cubic_linearizer.sv]
`timescale 1ns / 1ps

// Averaged-sample cubic linearizer.
// req_ channel: one 12-bit converter sample per transaction. Samples are
//   summed in groups of SAMPLES; the last sample of a group produces one
//   rsp_ transaction, the others produce none.
// rsp_ channel: truncated group mean, calibrated distance a+b*m+c*m^2+d*m^3
//   (signed Q10.8, rounded and clipped) and a saturated flag.
// csr_ channel: always ready; index 0..3 writes coefficient a, b, c, d
//   (signed Q.40), other indexes are ignored. Write only while idle.
// Front end takes one sample per cycle into a group accumulator and passes
//   finished sums through a 2-entry queue to the back end.
// Back end: pops a sum, divides by SAMPLES with a reciprocal multiply,
//   runs 3 rounds of multiply then saturating add, then rounds and clips
//   the result into the output register.
// Throughput: one sample per cycle while the queue has room; the back-end
//   sequencer finishes one group before it pops the next.
// Reset clears the group count and sum, the queue and the output valid flag,
//   and loads the default coefficients.
// When rsp_ready is low the result holds in the output register, the back
//   end waits in its round step, and the queue then fills and drops req_ready.

module averaged_sample_cubic_linearizer import ascl_pkg::*; #(
   parameter int SAMPLES = SAMPLES_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [SAMPLE_W-1:0]      req_sample,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [MEAN_W-1:0]        rsp_mean_value,
   output logic signed [DIST_W-1:0] rsp_distance,
   output logic                     rsp_saturated,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [CSR_IDX_W-1:0]     csr_index,
   input  logic signed [COEF_W-1:0] csr_wdata
);

   localparam int SUM_W = SAMPLE_W + $clog2(SAMPLES);

   q_status_type     q_stat;
   logic             push;
   logic [SUM_W-1:0] push_sum;
   logic             pop;
   logic [SUM_W-1:0] pop_sum;

   // group accumulation
   ascl_front #(
      .SAMPLES (SAMPLES),
      .SUM_W   (SUM_W)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_sample (req_sample),
      .q_stat     (q_stat),
      .push       (push),
      .push_sum   (push_sum)
   );

   // group sums waiting for the back end
   ascl_fifo #(
      .DATA_W (SUM_W)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_sum),
      .pop       (pop),
      .pop_data  (pop_sum),
      .q_stat    (q_stat)
   );

   // mean and polynomial evaluation
   ascl_back #(
      .SAMPLES (SAMPLES),
      .SUM_W   (SUM_W)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .q_stat         (q_stat),
      .pop_sum        (pop_sum),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_mean_value (rsp_mean_value),
      .rsp_distance   (rsp_distance),
      .rsp_saturated  (rsp_saturated)
   );

endmodule

[test/averaged_sample_cubic_linearizer_tb.sv]
`timescale 1ns / 1ps

module averaged_sample_cubic_linearizer_tb;
   import ascl_pkg::*;

   localparam int GROUP         = SAMPLES_DEF;
   localparam int MEAN_MAX      = 2**MEAN_W - 1;
   localparam int DIST_MAX      = 2**(DIST_W-1) - 1;
   localparam int DIST_MIN      = -(2**(DIST_W-1));
   localparam int PHASES        = 20;
   localparam int PHASE_SAMPLES = 41;
   localparam int SETTLE_CYCLES = 40;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int IDLE_HEAVY    = 78;
   localparam int IDLE_LIGHT    = 6;

   localparam logic [CSR_IDX_W-1:0] CSR_FIRST_UNUSED = CSR_IDX_W'(CSR_COEF_CUBE + 1);
   localparam logic [CSR_IDX_W-1:0] CSR_LAST_UNUSED  = CSR_IDX_W'(2**CSR_IDX_W - 1);

   localparam logic signed [COEF_W-1:0] COEF_HI = {1'b0, {(COEF_W-1){1'b1}}};
   localparam logic signed [COEF_W-1:0] COEF_LO = {1'b1, {(COEF_W-1){1'b0}}};

   // wide bounds for the saturating horner evaluation
   localparam logic signed [127:0] ACC_HI   = (128'sd1 <<< (ACC_W-1)) - 128'sd1;
   localparam logic signed [127:0] ACC_LO   = -(128'sd1 <<< (ACC_W-1));
   localparam logic signed [127:0] HALF_LSB = 128'sd1 <<< (FRAC_SHIFT-1);
   localparam logic signed [127:0] Q8_HI    = (128'sd1 <<< (DIST_W-1)) - 128'sd1;
   localparam logic signed [127:0] Q8_LO    = -(128'sd1 <<< (DIST_W-1));

   typedef enum int {SET_DEFAULT, SET_ALL_MAX, SET_ALL_MIN, SET_RAMP, SET_RANDOM} coef_set_type;
   typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_type;

   typedef struct {
      logic [MEAN_W-1:0]        mean;
      logic signed [DIST_W-1:0] distance;
      logic                     sat;
   } reading_type;

   // group accumulator and calibration predictor with its own coefficients
   class linearizer_scoreboard;
      logic signed [COEF_W-1:0] coef [4];
      int unsigned              sum;
      int                       taken;
      reading_type              expected_readings [$];
      int                       errors;
      int                       samples;
      int                       results;
      int                       sat_seen;

      function new();
         coef[CSR_COEF_CONST]  = COEF_CONST_RST;
         coef[CSR_COEF_LINEAR] = COEF_LINEAR_RST;
         coef[CSR_COEF_SQUARE] = COEF_SQUARE_RST;
         coef[CSR_COEF_CUBE]   = COEF_CUBE_RST;
         sum = 0;
         taken = 0;
         errors = 0;
         samples = 0;
         results = 0;
         sat_seen = 0;
      endfunction

      function void write_coef(logic [CSR_IDX_W-1:0] idx, logic signed [COEF_W-1:0] v);
         case (idx)
            CSR_COEF_CONST:  coef[CSR_COEF_CONST]  = v;
            CSR_COEF_LINEAR: coef[CSR_COEF_LINEAR] = v;
            CSR_COEF_SQUARE: coef[CSR_COEF_SQUARE] = v;
            CSR_COEF_CUBE:   coef[CSR_COEF_CUBE]   = v;
            default: ;
         endcase
      endfunction

      function logic signed [127:0] clamp_acc(logic signed [127:0] x);
         if (x > ACC_HI) return ACC_HI;
         if (x < ACC_LO) return ACC_LO;
         return x;
      endfunction

      // ((d*m + c)*m + b)*m + a, then round half up to q10.8 and clip
      function reading_type calibrate(logic [MEAN_W-1:0] m);
         logic signed [127:0] acc;
         logic signed [127:0] mw;
         logic signed [127:0] q;
         reading_type r;
         mw  = {116'd0, m};
         acc = 128'(coef[CSR_COEF_CUBE]);
         acc = clamp_acc(clamp_acc(acc * mw) + coef[CSR_COEF_SQUARE]);
         acc = clamp_acc(clamp_acc(acc * mw) + coef[CSR_COEF_LINEAR]);
         acc = clamp_acc(clamp_acc(acc * mw) + coef[CSR_COEF_CONST]);
         q = (acc + HALF_LSB) >>> FRAC_SHIFT;
         r.sat = (q > Q8_HI) || (q < Q8_LO);
         if (q > Q8_HI)
            q = Q8_HI;
         else if (q < Q8_LO)
            q = Q8_LO;
         r.mean = m;
         r.distance = q[DIST_W-1:0];
         return r;
      endfunction

      function void note_sample(logic [SAMPLE_W-1:0] s);
         logic [MEAN_W-1:0] m;
         samples++;
         sum += s;
         taken++;
         if (taken < GROUP) return;
         m = MEAN_W'(sum / GROUP);
         sum = 0;
         taken = 0;
         expected_readings.push_back(calibrate(m));
      endfunction

      function void check_result(logic [MEAN_W-1:0] mean, logic signed [DIST_W-1:0] distance,
                                 logic sat);
         reading_type r;
         results++;
         if (expected_readings.size() == 0) begin
            $error("unexpected result: mean_value %0d distance %0d saturated %0b",
                   mean, distance, sat);
            errors++;
            return;
         end
         r = expected_readings.pop_front();
         if (r.sat) sat_seen++;
         if (mean !== r.mean) begin
            $error("mean_value: expected %0d, actual %0d", r.mean, mean);
            errors++;
         end
         if (distance !== r.distance) begin
            $error("distance: expected %0d, actual %0d", r.distance, distance);
            errors++;
         end
         if (sat !== r.sat) begin
            $error("saturated: expected %0b, actual %0b", r.sat, sat);
            errors++;
         end
      endfunction

      function int pending();
         return expected_readings.size();
      endfunction
   endclass

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   logic [SAMPLE_W-1:0]      req_sample = '0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b1;
   logic [MEAN_W-1:0]        rsp_mean_value;
   logic signed [DIST_W-1:0] rsp_distance;
   logic                     rsp_saturated;
   logic                     csr_valid = 1'b0;
   logic                     csr_ready;
   logic [CSR_IDX_W-1:0]     csr_index = CSR_COEF_CONST;
   logic signed [COEF_W-1:0] csr_wdata = '0;

   linearizer_scoreboard sb;
   int send_pct  = 0;
   int stall_pct = 0;
   int cycle_count = 0;
   int settings_loaded = 0;

   averaged_sample_cubic_linearizer #(.SAMPLES(GROUP)) dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_sample     (req_sample),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_mean_value (rsp_mean_value),
      .rsp_distance   (rsp_distance),
      .rsp_saturated  (rsp_saturated),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // result side: check each accepted transaction, then pick the next ready
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_result(rsp_mean_value, rsp_distance, rsp_saturated);
      rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
                  sb.pending());
         $display("** averaged_sample_cubic_linearizer: FAILED **");
         $finish;
      end
   end

   // one sample transaction, with an optional idle gap before it
   task automatic send_sample(input logic [SAMPLE_W-1:0] s);
      if ($urandom_range(99) < send_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_pct);
      end
      req_valid  <= 1'b1;
      req_sample <= s;
      do @(posedge clock); while (!req_ready);
      sb.note_sample(s);
   endtask

   // one register write transaction; valid stays up for back-to-back writes
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic signed [COEF_W-1:0] v);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      do @(posedge clock); while (!csr_ready);
      sb.write_coef(idx, v);
   endtask

   // wait until every group result is back and the back end is quiet
   task automatic settle();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic logic signed [COEF_W-1:0] scaled_coef(int bits);
      longint r;
      r = {$urandom, $urandom};
      r = r >>> (64 - bits);
      return r[COEF_W-1:0];
   endfunction

   task automatic load_coefs(input coef_set_type kind);
      logic signed [COEF_W-1:0] a, b, c, d;
      int offs;
      a = COEF_CONST_RST;
      b = COEF_LINEAR_RST;
      c = COEF_SQUARE_RST;
      d = COEF_CUBE_RST;
      case (kind)
         SET_ALL_MAX: begin
            a = COEF_HI; b = COEF_HI; c = COEF_HI; d = COEF_HI;
         end
         SET_ALL_MIN: begin
            a = COEF_LO; b = COEF_LO; c = COEF_LO; d = COEF_LO;
         end
         SET_RAMP: begin
            // distance = offs + m - 1/2: ties round up, offsets sit on the clip edges
            case ($urandom_range(3))
               0: offs = 0;
               1: offs = DIST_MAX - MEAN_MAX;
               2: offs = DIST_MAX - MEAN_MAX + 1;
               default: offs = DIST_MIN - 1;
            endcase
            a = COEF_W'((longint'(offs) <<< FRAC_SHIFT) - (64'sd1 <<< (FRAC_SHIFT-1)));
            b = COEF_W'(64'sd1 <<< FRAC_SHIFT);
            c = '0;
            d = '0;
         end
         SET_RANDOM: begin
            a = scaled_coef(50 + $urandom_range(2));
            b = scaled_coef(38 + $urandom_range(2));
            c = scaled_coef(26 + $urandom_range(2));
            d = scaled_coef(14 + $urandom_range(2));
         end
         default: ;
      endcase
      // a write to an unused index must change nothing
      write_reg(CSR_IDX_W'($urandom_range(CSR_LAST_UNUSED, CSR_FIRST_UNUSED)),
                scaled_coef(COEF_W));
      write_reg(CSR_COEF_CONST, a);
      write_reg(CSR_COEF_LINEAR, b);
      write_reg(CSR_COEF_SQUARE, c);
      write_reg(CSR_COEF_CUBE, d);
      csr_valid <= 1'b0;
      settings_loaded++;
   endtask

   initial begin
      int center, spread, style, v;
      idle_mode_type mode;
      sb = new();
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed: a full-scale group, then a partial group that the first phase's samples complete
      repeat (GROUP) send_sample(MEAN_MAX);
      repeat (8) send_sample('0);
      send_sample(SAMPLE_W'(GROUP - 1));

      for (int ph = 0; ph < PHASES; ph++) begin
         settle();
         load_coefs(coef_set_type'(ph % 5));
         mode = idle_mode_type'(ph % 4);
         case (mode)
            IDLE_SENDER:   begin send_pct = IDLE_HEAVY; stall_pct = 0; end
            IDLE_RECEIVER: begin send_pct = 0; stall_pct = IDLE_HEAVY; end
            IDLE_BOTH:     begin send_pct = IDLE_LIGHT; stall_pct = IDLE_LIGHT; end
            default:       begin send_pct = 0; stall_pct = 0; end
         endcase
         center = 0;
         spread = 0;
         style  = 0;
         for (int i = 0; i < PHASE_SAMPLES; i++) begin
            // pick a new level and spread every GROUP samples so the means cover the range
            if (i % GROUP == 0) begin
               style  = $urandom_range(9);
               center = (style == 0) ? ($urandom_range(1) ? MEAN_MAX : 0)
                                     : $urandom_range(MEAN_MAX);
               spread = 1 << $urandom_range(11);
            end
            if (style == 0)
               v = center;
            else if (style == 1)
               v = $urandom_range(MEAN_MAX);
            else begin
               v = center + int'($urandom_range(2 * spread)) - spread;
               if (v < 0) v = 0;
               if (v > MEAN_MAX) v = MEAN_MAX;
            end
            send_sample(SAMPLE_W'(v));
         end
      end

      settle();
      $display("%0d samples in, %0d group results checked (%0d clipped)",
               sb.samples, sb.results, sb.sat_seen);
      $display("%0d coefficient settings across four idle patterns", settings_loaded);
      if (sb.errors == 0)
         $display("** averaged_sample_cubic_linearizer: PASSED **");
      else
         $display("** averaged_sample_cubic_linearizer: FAILED **");
      $finish;
   end

endmodule
